>>> hw/rtl/tsoqm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsoqm_pkg
// Shared constants, item types and codes of the timestamp ordered queue merge.
// ----------------------------------------------------------------------------
package tsoqm_pkg;

    localparam int NUM_SOURCES = 4;
    localparam int QUEUE_DEPTH = 16;

    localparam int SRC_W  = $clog2(NUM_SOURCES);
    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SCAN_W = $clog2(NUM_SOURCES + 1);
    localparam int STORE_DEPTH = NUM_SOURCES * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam int TIME_W    = 48;
    localparam int PAYLOAD_W = 32;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_EMIT    = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQUEUED  = 2'd0,
        ST_DROPPED   = 2'd1,
        ST_EMITTED   = 2'd2,
        ST_ALL_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic                 operation;
        logic [1:0]           source_index;
        logic [TIME_W-1:0]    record_time;
        logic [PAYLOAD_W-1:0] record_payload;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [1:0]           out_source;
        logic [TIME_W-1:0]    out_time;
        logic [PAYLOAD_W-1:0] out_payload;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0]    rec_time;
        logic [PAYLOAD_W-1:0] rec_payload;
    } t_rec;

    localparam int REC_W = $bits(t_rec);

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [SRC_W-1:0] s,
                                                    input logic [PTR_W-1:0] p);
        slot_addr = ADDR_W'(ADDR_W'(s) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p));
    endfunction

    function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
        ptr_advance = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tsoqm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsoqm_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tsoqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hw/rtl/timestamp_ordered_queue_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_ordered_queue_merge
// Per-source record FIFOs in one shared store, merged by smallest timestamp.
// ----------------------------------------------------------------------------
// One item is handled at a time and each gives exactly one result item. An
// enqueue goes from acceptance straight to the finish step; an emit first
// passes the head scan, which reads one queue head per cycle from the single
// read port of the record store and compares it against the running minimum.
// Ties go to the higher-numbered source. The result register frees the input
// side: a new item is taken while a result still waits downstream. No
// clearing pass.
// ----------------------------------------------------------------------------
module timestamp_ordered_queue_merge (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire tsoqm_pkg::t_in_item  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output tsoqm_pkg::t_out_item      o_out_data
);

    tsoqm_pkg::t_state r_state, n_state;
    tsoqm_pkg::t_in_item  r_item;
    tsoqm_pkg::t_out_item r_out, n_out;
    logic r_out_valid;

    logic [tsoqm_pkg::PTR_W-1:0]  r_rd_ptr [tsoqm_pkg::NUM_SOURCES];
    logic [tsoqm_pkg::PTR_W-1:0]  r_wr_ptr [tsoqm_pkg::NUM_SOURCES];
    logic [tsoqm_pkg::FILL_W-1:0] r_fill   [tsoqm_pkg::NUM_SOURCES];

    logic [tsoqm_pkg::SCAN_W-1:0]    r_scan;
    logic                            r_pend;
    logic [tsoqm_pkg::SRC_W-1:0]     r_pend_src;
    logic                            r_found;
    logic [tsoqm_pkg::SRC_W-1:0]     r_best_src;
    logic [tsoqm_pkg::TIME_W-1:0]    r_best_time;
    logic [tsoqm_pkg::PAYLOAD_W-1:0] r_best_payload;

    logic                         in_acc;
    logic                         out_free;
    logic                         is_emit;
    logic                         commit;
    logic                         scan_end;
    logic [tsoqm_pkg::SRC_W-1:0]  scan_idx;
    logic [tsoqm_pkg::SRC_W-1:0]  enq_src;
    logic                         enq_ok;
    logic                         take;
    logic                         ram_we, ram_re;
    logic [tsoqm_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    tsoqm_pkg::t_rec              ram_wdata, ram_rdata;

    tsoqm_ram #(
        .WIDTH (tsoqm_pkg::REC_W),
        .DEPTH (tsoqm_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            tsoqm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_data.operation == tsoqm_pkg::OP_EMIT) ?
                              tsoqm_pkg::S_SCAN : tsoqm_pkg::S_FINISH;
                end
            end
            tsoqm_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = tsoqm_pkg::S_FINISH;
                end
            end
            tsoqm_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = tsoqm_pkg::S_IDLE;
                end
            end
            default: n_state = tsoqm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == tsoqm_pkg::S_IDLE);
        in_acc     = i_in_valid && o_in_ready;
        out_free   = !r_out_valid || i_out_ready;
        is_emit    = (r_item.operation == tsoqm_pkg::OP_EMIT);
        commit     = (r_state == tsoqm_pkg::S_FINISH) && out_free;

        scan_end = (r_scan == tsoqm_pkg::SCAN_W'(tsoqm_pkg::NUM_SOURCES));
        scan_idx = scan_end ? '0 : r_scan[tsoqm_pkg::SRC_W-1:0];
        enq_src  = tsoqm_pkg::SRC_W'(r_item.source_index);
        enq_ok   = (32'(r_item.source_index) < tsoqm_pkg::NUM_SOURCES) &&
                   (r_fill[enq_src] < tsoqm_pkg::FILL_W'(tsoqm_pkg::QUEUE_DEPTH));

        ram_re    = (r_state == tsoqm_pkg::S_SCAN) && !scan_end;
        ram_raddr = tsoqm_pkg::slot_addr(scan_idx, r_rd_ptr[scan_idx]);
        ram_we    = commit && !is_emit && enq_ok;
        ram_waddr = tsoqm_pkg::slot_addr(enq_src, r_wr_ptr[enq_src]);
        ram_wdata.rec_time    = r_item.record_time;
        ram_wdata.rec_payload = r_item.record_payload;

        take = r_pend && (!r_found || ram_rdata.rec_time <= r_best_time);

        n_out = '0;
        if (!is_emit) begin
            n_out.status = enq_ok ? tsoqm_pkg::ST_ENQUEUED : tsoqm_pkg::ST_DROPPED;
        end else if (r_found) begin
            n_out.status      = tsoqm_pkg::ST_EMITTED;
            n_out.out_source  = 2'(r_best_src);
            n_out.out_time    = r_best_time;
            n_out.out_payload = r_best_payload;
        end else begin
            n_out.status = tsoqm_pkg::ST_ALL_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsoqm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_scan      <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            for (int s = 0; s < tsoqm_pkg::NUM_SOURCES; s++) begin
                r_rd_ptr[s] <= '0;
                r_wr_ptr[s] <= '0;
                r_fill[s]   <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pend  <= ram_re && (r_fill[scan_idx] != '0);
            if (in_acc) begin
                r_scan  <= '0;
                r_found <= 1'b0;
            end else if (r_state == tsoqm_pkg::S_SCAN) begin
                if (!scan_end) begin
                    r_scan <= tsoqm_pkg::SCAN_W'(r_scan + 1'b1);
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (commit) begin
                r_out_valid <= 1'b1;
                if (!is_emit && enq_ok) begin
                    r_wr_ptr[enq_src] <= tsoqm_pkg::ptr_advance(r_wr_ptr[enq_src]);
                    r_fill[enq_src]   <= tsoqm_pkg::FILL_W'(r_fill[enq_src] + 1'b1);
                end else if (is_emit && r_found) begin
                    r_rd_ptr[r_best_src] <= tsoqm_pkg::ptr_advance(r_rd_ptr[r_best_src]);
                    r_fill[r_best_src]   <= tsoqm_pkg::FILL_W'(r_fill[r_best_src] - 1'b1);
                end
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        r_pend_src <= scan_idx;
        if ((r_state == tsoqm_pkg::S_SCAN) && take) begin
            r_best_src     <= r_pend_src;
            r_best_time    <= ram_rdata.rec_time;
            r_best_payload <= ram_rdata.rec_payload;
        end
        if (commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_store_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("store written and read in the same cycle");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input still ready after taking an item");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && is_emit && r_found) |-> (r_fill[r_best_src] != '0))
        else $error("emit pops an empty queue");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == tsoqm_pkg::S_FINISH))
        else $error("result raised outside the finish step");

endmodule
`default_nettype wire
